// ===== rtl/core/ugl_pkg.sv =====
// ----------------------------------------------------------------------------
// ugl_pkg
// Shared types and constants of the UTF-8 glyph locator.
// ----------------------------------------------------------------------------
package ugl_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_FONT_SIZE        = 3'd0;
    localparam logic [2:0] CFG_NORMAL_HEIGHT    = 3'd1;
    localparam logic [2:0] CFG_NORMAL_WIDTH     = 3'd2;
    localparam logic [2:0] CFG_LARGE_HEIGHT     = 3'd3;
    localparam logic [2:0] CFG_LARGE_WIDTH      = 3'd4;
    localparam logic [2:0] CFG_ASCII_BASE       = 3'd5;
    localparam logic [2:0] CFG_LARGE_ASCII_BASE = 3'd6;
    localparam logic [2:0] CFG_UNICODE_BASE     = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_FONT_SIZE     = 16'h180C;
    localparam logic [7:0]  RST_NORMAL_HEIGHT = 8'd24;
    localparam logic [7:0]  RST_NORMAL_WIDTH  = 8'd12;
    localparam logic [7:0]  RST_LARGE_HEIGHT  = 8'd32;
    localparam logic [7:0]  RST_LARGE_WIDTH   = 8'd16;

    // Code point limits
    localparam logic [20:0] CP_MIN_GLYPH   = 21'h9;
    localparam logic [20:0] CP_ASCII_FIRST = 21'h20;
    localparam logic [20:0] CP_ASCII_LAST  = 21'h7E;
    localparam logic [20:0] CP_LATIN_FIRST = 21'h80;
    localparam logic [20:0] CP_LATIN_LAST  = 21'h24F;
    localparam logic [20:0] CP_GREEK_FIRST = 21'h370;
    localparam logic [20:0] CP_CYRIL_LAST  = 21'h451;
    localparam logic [20:0] CP_ARMEN_FIRST = 21'h530;
    localparam logic [20:0] CP_ARMEN_LAST  = 21'h58F;
    localparam logic [20:0] CP_BMP_LAST    = 21'hFFFF;
    localparam logic [20:0] CP_REPLACEMENT = 21'h3F;

    typedef struct packed {
        logic take;   // accept the byte and step the decoder
        logic load;   // move the staged result into the output register
    } ugl_cmd_t;

    typedef struct packed {
        logic emit;   // the byte on the input completes a result
    } ugl_status_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [8:0]  glyph_width;
        logic [7:0]  glyph_height;
        logic [31:0] bitmap_addr;
        logic        no_glyph;
        logic        end_of_string;
        logic [15:0] total_width;
        logic [15:0] char_count;
    } ugl_result_t;

endpackage

// ===== rtl/core/ugl_byte_if.sv =====
// ----------------------------------------------------------------------------
// ugl_byte_if
// Text byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ugl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== rtl/core/ugl_result_if.sv =====
// ----------------------------------------------------------------------------
// ugl_result_if
// Glyph result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ugl_result_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [8:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [31:0] bitmap_addr;
    logic        no_glyph;
    logic        end_of_string;
    logic [15:0] total_width;
    logic [15:0] char_count;

    modport source (output valid, output code_point, output glyph_width,
                    output glyph_height, output bitmap_addr, output no_glyph,
                    output end_of_string, output total_width, output char_count,
                    input ready);
    modport sink   (input valid, input code_point, input glyph_width,
                    input glyph_height, input bitmap_addr, input no_glyph,
                    input end_of_string, input total_width, input char_count,
                    output ready);
endinterface

// ===== rtl/core/ugl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ugl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ugl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/utf8_glyph_locator_core.sv =====
// ----------------------------------------------------------------------------
// utf8_glyph_locator_core
// UTF-8 decoder with glyph range lookup, bitmap address and running totals.
// ----------------------------------------------------------------------------
// Usage:
//   text  - sink of text bytes, one item per byte; a zero byte ends the string.
//   glyph - source of result items: code point, glyph size, bitmap address,
//           no_glyph flag, end_of_string flag and the running totals.
//   cfg   - register writes (index 0..7), always ready; write only while idle.
// Operation:
//   A byte that completes a character or ends the string is decoded and
//   range-matched as it is accepted and held in the staging registers. Once
//   the output register is free, the offset-times-bytes-per-glyph multiply
//   and the base add go into the output register, whose valid then rises.
//   A lead byte or an inner continuation byte gives no result.
//   No new byte is accepted until the staged result has been loaded.
// Stall:
//   The output register holds a result while glyph.ready is low; the next
//   byte is still accepted and staged, and then text.ready drops until the
//   output register frees up.
// Reset:
//   rst_n clears the decoder, totals and output valid, and loads the register
//   reset values. The block is ready for bytes straight out of reset.
// ----------------------------------------------------------------------------
module utf8_glyph_locator_core
    import ugl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ugl_byte_if.sink     text,
    ugl_result_if.source glyph,
    ugl_cfg_if.sink      cfg
);

    ugl_cmd_t    cmd;
    ugl_status_t status;
    ugl_result_t result;

    // Config registers take a write in any cycle
    assign cfg.ready = 1'b1;

    ugl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text.valid),
        .text_ready  (text.ready),
        .glyph_valid (glyph.valid),
        .glyph_ready (glyph.ready),
        .status      (status),
        .cmd         (cmd)
    );

    ugl_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .byte_in   (text.byte_in),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    // Drive the result channel payload from the output register
    assign glyph.code_point    = result.code_point;
    assign glyph.glyph_width   = result.glyph_width;
    assign glyph.glyph_height  = result.glyph_height;
    assign glyph.bitmap_addr   = result.bitmap_addr;
    assign glyph.no_glyph      = result.no_glyph;
    assign glyph.end_of_string = result.end_of_string;
    assign glyph.total_width   = result.total_width;
    assign glyph.char_count    = result.char_count;

endmodule

// ===== rtl/core/ugl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ugl_ctrl
// Sequencer: byte acceptance, result staging and output register valid.
// ----------------------------------------------------------------------------
module ugl_ctrl
    import ugl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    output logic        glyph_valid,
    input  logic        glyph_ready,
    input  ugl_status_t status,
    output ugl_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic take, load;

    assign text_ready  = (state_reg == ST_IDLE);
    assign take        = text_valid && text_ready;
    // Load a staged result when busy and the output register is empty or drains this cycle
    assign load        = (state_reg == ST_BUSY) && (!out_valid_reg || glyph_ready);
    assign glyph_valid = out_valid_reg;
    assign cmd.take    = take;
    assign cmd.load    = load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && status.emit)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (glyph_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/ugl_dpath.sv =====
// ----------------------------------------------------------------------------
// ugl_dpath
// Datapath: config registers, UTF-8 decode, range match, address and totals.
// ----------------------------------------------------------------------------
module ugl_dpath
    import ugl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [7:0]  byte_in,
    input  ugl_cmd_t    cmd,
    output ugl_status_t status,
    output ugl_result_t result
);

    // Configuration registers
    logic [15:0] font_size_reg;
    logic [7:0]  normal_height_reg, normal_width_reg;
    logic [7:0]  large_height_reg, large_width_reg;
    logic [31:0] ascii_base_reg, large_ascii_base_reg, unicode_base_reg;

    // Bytes per glyph, straight from the config registers
    logic [15:0] normal_area, large_area;
    logic [12:0] bpg_normal, bpg_large;
    logic [13:0] bpg_unicode;

    // Decoder state and totals
    logic [1:0]  pend_reg, pend_next;
    logic [20:0] accum_reg, accum_next;
    logic [15:0] width_sum_reg, width_sum_next;
    logic [15:0] count_sum_reg, count_sum_next;

    // Staged character
    logic [20:0] st_cp_reg;
    logic        st_eos_reg, st_none_reg;
    logic [8:0]  st_gw_reg;
    logic [7:0]  st_gh_reg;
    logic [31:0] st_base_reg;
    logic [15:0] st_off_reg;
    logic [13:0] st_bpg_reg;

    // Decode outputs
    logic [20:0] cont_cp, dec_cp;
    logic        dec_emit, dec_eos;

    // Match outputs
    logic        in_ascii, in_unicode_set;
    logic        font_normal, font_large, font_double;
    logic [8:0]  m_gw;
    logic [7:0]  m_gh;
    logic [31:0] m_base;
    logic [15:0] m_off;
    logic [13:0] m_bpg;
    logic        m_none;
    logic [15:0] ascii_off;

    logic [29:0] off_product;
    ugl_result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_size_reg        <= RST_FONT_SIZE;
            normal_height_reg    <= RST_NORMAL_HEIGHT;
            normal_width_reg     <= RST_NORMAL_WIDTH;
            large_height_reg     <= RST_LARGE_HEIGHT;
            large_width_reg      <= RST_LARGE_WIDTH;
            ascii_base_reg       <= '0;
            large_ascii_base_reg <= '0;
            unicode_base_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FONT_SIZE:        font_size_reg        <= cfg_data[15:0];
                CFG_NORMAL_HEIGHT:    normal_height_reg    <= cfg_data[7:0];
                CFG_NORMAL_WIDTH:     normal_width_reg     <= cfg_data[7:0];
                CFG_LARGE_HEIGHT:     large_height_reg     <= cfg_data[7:0];
                CFG_LARGE_WIDTH:      large_width_reg      <= cfg_data[7:0];
                CFG_ASCII_BASE:       ascii_base_reg       <= cfg_data;
                CFG_LARGE_ASCII_BASE: large_ascii_base_reg <= cfg_data;
                CFG_UNICODE_BASE:     unicode_base_reg     <= cfg_data;
                default:              font_size_reg        <= font_size_reg;
            endcase
        end
    end

    assign normal_area = 16'(normal_height_reg) * 16'(normal_width_reg);
    assign large_area  = 16'(large_height_reg) * 16'(large_width_reg);

    assign bpg_normal  = normal_area[15:3];
    assign bpg_large   = large_area[15:3];
    // twice the width, then divided by 8
    assign bpg_unicode = normal_area[15:2];

    // UTF-8 decode
    assign cont_cp = {accum_reg[14:0], byte_in[5:0]};

    always_comb
    begin
        pend_next  = pend_reg;
        accum_next = accum_reg;
        dec_emit   = 1'b0;
        dec_eos    = 1'b0;
        dec_cp     = '0;
        priority if (byte_in == 8'h00)
        begin
            dec_emit   = 1'b1;
            dec_eos    = 1'b1;
            pend_next  = 2'd0;
            accum_next = '0;
        end
        else if (pend_reg != 2'd0)
        begin
            pend_next = pend_reg - 2'd1;
            dec_cp    = cont_cp;
            if (pend_reg == 2'd1)
            begin
                dec_emit   = 1'b1;
                accum_next = '0;
            end
            else
            begin
                accum_next = cont_cp;
            end
        end
        else if (!byte_in[7])
        begin
            dec_emit = 1'b1;
            dec_cp   = 21'(byte_in);
        end
        else if (byte_in[7:5] == 3'b110)
        begin
            pend_next  = 2'd1;
            accum_next = 21'(byte_in[4:0]);
        end
        else if (byte_in[7:4] == 4'b1110)
        begin
            pend_next  = 2'd2;
            accum_next = 21'(byte_in[3:0]);
        end
        else if (byte_in[7:3] == 5'b11110)
        begin
            pend_next  = 2'd3;
            accum_next = 21'(byte_in[2:0]);
        end
        else
        begin
            dec_emit = 1'b1;
            dec_cp   = CP_REPLACEMENT;
        end
    end

    assign status.emit = dec_emit;

    // Range match on the decoded code point
    assign in_ascii       = (dec_cp >= CP_ASCII_FIRST) && (dec_cp <= CP_ASCII_LAST);
    assign in_unicode_set = ((dec_cp >= CP_LATIN_FIRST) && (dec_cp <= CP_LATIN_LAST))
                         || ((dec_cp >= CP_GREEK_FIRST) && (dec_cp <= CP_CYRIL_LAST))
                         || ((dec_cp >= CP_ARMEN_FIRST) && (dec_cp <= CP_ARMEN_LAST));
    assign font_normal = (font_size_reg[15:8] == normal_height_reg)
                      && (font_size_reg[7:0] == normal_width_reg);
    assign font_large  = (font_size_reg[15:8] == large_height_reg)
                      && (font_size_reg[7:0] == large_width_reg);
    assign font_double = (font_size_reg[15:8] == normal_height_reg)
                      && ({1'b0, font_size_reg[7:0]} == {normal_width_reg, 1'b0});
    assign ascii_off   = dec_cp[15:0] - CP_ASCII_FIRST[15:0];

    always_comb
    begin
        m_gw   = '0;
        m_gh   = '0;
        m_base = '0;
        m_off  = '0;
        m_bpg  = '0;
        m_none = 1'b0;
        priority if (dec_eos || (dec_cp < CP_MIN_GLYPH))
        begin
            m_none = 1'b0;
        end
        else if (in_ascii && font_normal)
        begin
            m_gw   = {1'b0, normal_width_reg};
            m_gh   = normal_height_reg;
            m_base = ascii_base_reg;
            m_off  = ascii_off;
            m_bpg  = {1'b0, bpg_normal};
        end
        else if (in_ascii && font_large)
        begin
            m_gw   = {1'b0, large_width_reg};
            m_gh   = large_height_reg;
            m_base = large_ascii_base_reg;
            m_off  = ascii_off;
            m_bpg  = {1'b0, bpg_large};
        end
        else if (in_ascii && font_double)
        begin
            m_gw   = {normal_width_reg, 1'b0};
            m_gh   = normal_height_reg;
            m_base = unicode_base_reg;
            m_off  = dec_cp[15:0];
            m_bpg  = bpg_unicode;
        end
        else if (in_ascii)
        begin
            m_none = 1'b1;
        end
        else if (in_unicode_set)
        begin
            m_gw   = {1'b0, normal_width_reg};
            m_gh   = normal_height_reg;
            m_base = unicode_base_reg;
            m_off  = dec_cp[15:0];
            m_bpg  = bpg_unicode;
        end
        else if (dec_cp <= CP_BMP_LAST)
        begin
            m_gw   = {normal_width_reg, 1'b0};
            m_gh   = normal_height_reg;
            m_base = unicode_base_reg;
            m_off  = dec_cp[15:0];
            m_bpg  = bpg_unicode;
        end
        else
        begin
            m_none = 1'b1;
        end
    end

    // Stage the character on acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            st_cp_reg   <= dec_cp;
            st_eos_reg  <= dec_eos;
            st_gw_reg   <= m_gw;
            st_gh_reg   <= m_gh;
            st_base_reg <= m_base;
            st_off_reg  <= m_off;
            st_bpg_reg  <= m_bpg;
            st_none_reg <= m_none;
        end
    end

    // Totals: end of string reports and clears
    assign off_product = 30'(st_off_reg) * 30'(st_bpg_reg);

    always_comb
    begin
        if (st_eos_reg)
        begin
            width_sum_next = '0;
            count_sum_next = '0;
        end
        else
        begin
            width_sum_next = width_sum_reg + 16'(st_gw_reg);
            count_sum_next = count_sum_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 2'd0;
            accum_reg     <= '0;
            width_sum_reg <= '0;
            count_sum_reg <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                pend_reg  <= pend_next;
                accum_reg <= accum_next;
            end
            if (cmd.load)
            begin
                width_sum_reg <= width_sum_next;
                count_sum_reg <= count_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            result_reg.code_point    <= st_cp_reg;
            result_reg.glyph_width   <= st_gw_reg;
            result_reg.glyph_height  <= st_gh_reg;
            result_reg.bitmap_addr   <= st_base_reg + 32'(off_product);
            result_reg.no_glyph      <= st_none_reg;
            result_reg.end_of_string <= st_eos_reg;
            result_reg.total_width   <= st_eos_reg ? width_sum_reg : width_sum_next;
            result_reg.char_count    <= st_eos_reg ? count_sum_reg : count_sum_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams UTF-8 text into utf8_glyph_locator_core under several register
// settings and random idling on both channels. Each glyph result is checked
// field by field against a local prediction of the decoder, range table and
// running totals.
// ----------------------------------------------------------------------------
module testbench;
    import ugl_pkg::*;

    // Range limits the package does not name
    localparam logic [20:0] CP_GREEK_LAST  = 21'h3FF;
    localparam logic [20:0] CP_CYRIL_FIRST = 21'h400;

    // UTF-8 lead and continuation markers
    localparam logic [2:0] LEAD_TWO   = 3'b110;
    localparam logic [3:0] LEAD_THREE = 4'b1110;
    localparam logic [4:0] LEAD_FOUR  = 5'b11110;
    localparam logic [1:0] CONT_MARK  = 2'b10;

    localparam logic [7:0]  END_OF_TEXT  = 8'h00;
    localparam int unsigned STEADY_CHARS = 100;     // gap-free string near the end
    localparam int unsigned REPORT_LIMIT = 60;      // cap on printed mismatches

    // ------------------------------------------------------------------------
    // Glyph tracker: predicts the result of each accepted byte, holds the
    // expected results in order and checks what comes out of the block.
    // ------------------------------------------------------------------------
    class glyph_tracker;
        logic [15:0] font_size;
        logic [7:0]  normal_height, normal_width, large_height, large_width;
        logic [31:0] ascii_base, large_ascii_base, unicode_base;

        logic [1:0]  bytes_left;
        logic [20:0] code_accum;
        logic [15:0] width_total, count_total;

        ugl_result_t expected_glyphs[$];
        int unsigned errors, bytes_seen, results_checked, strings_ended, no_glyph_seen;

        function new();
            font_size        = RST_FONT_SIZE;
            normal_height    = RST_NORMAL_HEIGHT;
            normal_width     = RST_NORMAL_WIDTH;
            large_height     = RST_LARGE_HEIGHT;
            large_width      = RST_LARGE_WIDTH;
            ascii_base       = '0;
            large_ascii_base = '0;
            unicode_base     = '0;
            bytes_left       = '0;
            code_accum       = '0;
            width_total      = '0;
            count_total      = '0;
        endfunction

        function void set_register(logic [2:0] reg_index, logic [31:0] data);
            case (reg_index)
                CFG_FONT_SIZE:        font_size        = data[15:0];
                CFG_NORMAL_HEIGHT:    normal_height    = data[7:0];
                CFG_NORMAL_WIDTH:     normal_width     = data[7:0];
                CFG_LARGE_HEIGHT:     large_height     = data[7:0];
                CFG_LARGE_WIDTH:      large_width      = data[7:0];
                CFG_ASCII_BASE:       ascii_base       = data;
                CFG_LARGE_ASCII_BASE: large_ascii_base = data;
                CFG_UNICODE_BASE:     unicode_base     = data;
                default: ;
            endcase
        endfunction

        // One table range; ASCII code points also need the selected font to match
        function bit try_range(int unsigned cp, int unsigned lo, int unsigned hi,
                               int unsigned w, int unsigned h, int unsigned base,
                               int unsigned bw, int unsigned first,
                               output int unsigned gw, output int unsigned gh,
                               output int unsigned addr);
            gw   = 0;
            gh   = 0;
            addr = 0;
            if (cp < lo || cp > hi)
                return 1'b0;
            if (cp >= CP_ASCII_FIRST && cp <= CP_ASCII_LAST &&
                (font_size[15:8] != h || font_size[7:0] != w))
                return 1'b0;
            gw   = w;
            gh   = h;
            addr = base + (cp - first) * ((h * bw) / 8);
            return 1'b1;
        endfunction

        // Look up a finished character and advance the totals
        function ugl_result_t locate_glyph(int unsigned cp);
            ugl_result_t r;
            int unsigned gw, gh, addr, nw, nw2, nh;
            bit found;
            r   = '0;
            gw  = 0;
            gh  = 0;
            addr = 0;
            nw  = normal_width;
            nh  = normal_height;
            nw2 = nw * 2;
            if (cp >= CP_MIN_GLYPH) begin
                found = try_range(cp, CP_ASCII_FIRST, CP_ASCII_LAST, nw, nh, ascii_base,
                                  nw, CP_ASCII_FIRST, gw, gh, addr);
                if (!found)
                    found = try_range(cp, CP_ASCII_FIRST, CP_ASCII_LAST, large_width,
                                      large_height, large_ascii_base, large_width,
                                      CP_ASCII_FIRST, gw, gh, addr);
                if (!found)
                    found = try_range(cp, CP_LATIN_FIRST, CP_LATIN_LAST, nw, nh,
                                      unicode_base, nw2, 0, gw, gh, addr);
                if (!found)
                    found = try_range(cp, CP_GREEK_FIRST, CP_GREEK_LAST, nw, nh,
                                      unicode_base, nw2, 0, gw, gh, addr);
                if (!found)
                    found = try_range(cp, CP_CYRIL_FIRST, CP_CYRIL_LAST, nw, nh,
                                      unicode_base, nw2, 0, gw, gh, addr);
                if (!found)
                    found = try_range(cp, CP_ARMEN_FIRST, CP_ARMEN_LAST, nw, nh,
                                      unicode_base, nw2, 0, gw, gh, addr);
                if (!found)
                    found = try_range(cp, CP_MIN_GLYPH, CP_BMP_LAST, nw2, nh,
                                      unicode_base, nw2, 0, gw, gh, addr);
                r.no_glyph = !found;
            end
            width_total    = width_total + gw[15:0];
            count_total    = count_total + 16'd1;
            r.code_point   = cp[20:0];
            r.glyph_width  = gw[8:0];
            r.glyph_height = gh[7:0];
            r.bitmap_addr  = addr;
            r.total_width  = width_total;
            r.char_count   = count_total;
            return r;
        endfunction

        // Step the decoder with one accepted byte
        function void decode_byte(logic [7:0] b);
            ugl_result_t r;
            bytes_seen++;
            if (b == END_OF_TEXT) begin
                // Totals as they stood; any partial character is dropped
                r               = '0;
                r.end_of_string = 1'b1;
                r.total_width   = width_total;
                r.char_count    = count_total;
                expected_glyphs.push_back(r);
                bytes_left  = '0;
                code_accum  = '0;
                width_total = '0;
                count_total = '0;
            end else if (bytes_left != 0) begin
                // Continuation bytes are not checked, only their low six bits count
                code_accum = {code_accum[14:0], b[5:0]};
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == 0) begin
                    expected_glyphs.push_back(locate_glyph(code_accum));
                    code_accum = '0;
                end
            end else if (!b[7]) begin
                expected_glyphs.push_back(locate_glyph(b));
            end else if (b[7:5] == LEAD_TWO) begin
                code_accum = 21'(b[4:0]);
                bytes_left = 2'd1;
            end else if (b[7:4] == LEAD_THREE) begin
                code_accum = 21'(b[3:0]);
                bytes_left = 2'd2;
            end else if (b[7:3] == LEAD_FOUR) begin
                code_accum = 21'(b[2:0]);
                bytes_left = 2'd3;
            end else begin
                // Stray continuation or invalid lead stands for '?'
                expected_glyphs.push_back(locate_glyph(CP_REPLACEMENT));
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
            end
        endfunction

        function void check_glyph(ugl_result_t seen);
            ugl_result_t want;
            if (expected_glyphs.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $error("result with nothing expected, code_point 0x%0h", seen.code_point);
                return;
            end
            want = expected_glyphs.pop_front();
            results_checked++;
            if (want.end_of_string)
                strings_ended++;
            if (want.no_glyph)
                no_glyph_seen++;
            compare_field("code_point",    want.code_point,    seen.code_point);
            compare_field("glyph_width",   want.glyph_width,   seen.glyph_width);
            compare_field("glyph_height",  want.glyph_height,  seen.glyph_height);
            compare_field("bitmap_addr",   want.bitmap_addr,   seen.bitmap_addr);
            compare_field("no_glyph",      want.no_glyph,      seen.no_glyph);
            compare_field("end_of_string", want.end_of_string, seen.end_of_string);
            compare_field("total_width",   want.total_width,   seen.total_width);
            compare_field("char_count",    want.char_count,    seen.char_count);
        endfunction

        function int unsigned waiting();
            return expected_glyphs.size();
        endfunction

        function void final_check();
            if (expected_glyphs.size() != 0) begin
                errors += expected_glyphs.size();
                $error("%0d expected results never arrived", expected_glyphs.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ugl_byte_if   text_ch ();
    ugl_result_if glyph_ch ();
    ugl_cfg_if    cfg_ch ();

    utf8_glyph_locator_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .glyph (glyph_ch),
        .cfg   (cfg_ch)
    );

    glyph_tracker tracker = new();

    logic [7:0]  text_plan[$];     // bytes waiting to be sent
    bit          tx_steady = 1'b0; // sender runs without gaps
    bit          rx_steady = 1'b0; // receiver runs without stalls
    bit          rx_free   = 1'b0; // receiver forced always ready
    int unsigned configs_loaded = 0;

    // Directed opening text, all at the reset register values:
    // ASCII at both ends of the normal range, DEL and a control char that
    // land in the default range, two code points below 9, one character of each
    // unicode range, a BMP ideograph, an emoji beyond the table, a stray
    // continuation, an invalid lead, a zero inside a character and a plain
    // end of string.
    logic [7:0] opening_text[$] = '{
        8'h41, 8'h20, 8'h7E, 8'h7F, 8'h09, 8'h08, 8'h01,
        8'hC3, 8'hA9, 8'hCE, 8'hB1, 8'hD0, 8'h96, 8'hD5, 8'hA1,
        8'hE4, 8'hB8, 8'hAD, 8'hF0, 8'h9F, 8'h98, 8'h80,
        8'h80, 8'hFF, 8'hC3, 8'h00, 8'h00
    };

    // ------------------------------------------------------------------------
    // Monitor: sample both sides at the rising edge. Check results before
    // noting a byte taken at the same edge, since a result always belongs to
    // an earlier byte.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        ugl_result_t seen;
        if (rst_n) begin
            if (glyph_ch.valid === 1'b1 && glyph_ch.ready === 1'b1) begin
                seen = {glyph_ch.code_point, glyph_ch.glyph_width, glyph_ch.glyph_height,
                        glyph_ch.bitmap_addr, glyph_ch.no_glyph, glyph_ch.end_of_string,
                        glyph_ch.total_width, glyph_ch.char_count};
                tracker.check_glyph(seen);
            end
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
                tracker.set_register(cfg_ch.index, cfg_ch.data);
            if (text_ch.valid === 1'b1 && text_ch.ready === 1'b1)
                tracker.decode_byte(text_ch.byte_in);
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap(bit steady);
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: drop ready for random stretches, with runs of no stalls
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        glyph_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_free)
                stall_left = 0;
            if (stall_left != 0) begin
                glyph_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                glyph_ch.ready <= 1'b1;
                if (!rx_free && !rx_steady && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap(1'b0);
            end
            if ($urandom_range(0, 399) == 0)
                rx_steady = !rx_steady;
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Present one byte after an optional gap and hold it until taken
    task automatic send_byte(logic [7:0] value, int unsigned gap);
        @(negedge clk);
        if (gap != 0) begin
            text_ch.valid   <= 1'b0;
            text_ch.byte_in <= 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        text_ch.valid   <= 1'b1;
        text_ch.byte_in <= value;
        @(posedge clk);
        while (text_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic send_plan();
        while (text_plan.size() != 0)
            send_byte(text_plan.pop_front(), pick_gap(tx_steady));
    endtask

    // Hold the sender until every expected result is in or a guard runs out,
    // then let the block settle in case a lead byte is still in flight
    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (tracker.waiting() != 0 && guard < 2000) begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] reg_index, logic [31:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= reg_index;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Write all eight registers; narrow ones get junk in the unused bits
    task automatic load_config(logic [15:0] font, logic [7:0] nh, logic [7:0] nw,
                               logic [7:0] lh, logic [7:0] lw, logic [31:0] ab,
                               logic [31:0] lb, logic [31:0] ub);
        write_register(CFG_FONT_SIZE,        {16'($urandom), font});
        write_register(CFG_NORMAL_HEIGHT,    {24'($urandom), nh});
        write_register(CFG_NORMAL_WIDTH,     {24'($urandom), nw});
        write_register(CFG_LARGE_HEIGHT,     {24'($urandom), lh});
        write_register(CFG_LARGE_WIDTH,      {24'($urandom), lw});
        write_register(CFG_ASCII_BASE,       ab);
        write_register(CFG_LARGE_ASCII_BASE, lb);
        write_register(CFG_UNICODE_BASE,     ub);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        configs_loaded++;
    endtask

    // Queue a well-formed encoding of cp in len bytes (overlong allowed)
    function automatic void plan_code(int unsigned cp, int unsigned len);
        logic [20:0] c;
        c = cp[20:0];
        case (len)
            1: text_plan.push_back({1'b0, c[6:0]});
            2: begin
                text_plan.push_back({LEAD_TWO, c[10:6]});
                text_plan.push_back({CONT_MARK, c[5:0]});
            end
            3: begin
                text_plan.push_back({LEAD_THREE, c[15:12]});
                text_plan.push_back({CONT_MARK, c[11:6]});
                text_plan.push_back({CONT_MARK, c[5:0]});
            end
            default: begin
                text_plan.push_back({LEAD_FOUR, c[20:18]});
                text_plan.push_back({CONT_MARK, c[17:12]});
                text_plan.push_back({CONT_MARK, c[11:6]});
                text_plan.push_back({CONT_MARK, c[5:0]});
            end
        endcase
    endfunction

    // Queue one unit of random text: mostly well-formed characters aimed at
    // the table ranges, plus bad leads, broken sequences, raw noise and ends
    function automatic void plan_unit();
        int unsigned roll, cp, len, k;
        int unsigned range_edges[] = '{'h80, 'h24F, 'h250, 'h36F, 'h370, 'h3FF, 'h400,
                                       'h451, 'h452, 'h52F, 'h530, 'h58F, 'h590, 'h7FF};
        roll = $urandom_range(0, 99);
        if (roll < 33) begin
            if ($urandom_range(0, 4) != 0)
                cp = $urandom_range(CP_ASCII_FIRST, CP_ASCII_LAST);
            else
                cp = $urandom_range(1, 127);
            plan_code(cp, 1);
        end else if (roll < 58) begin
            case ($urandom_range(0, 6))
                0: cp = $urandom_range(CP_LATIN_FIRST, CP_LATIN_LAST);
                1: cp = $urandom_range(CP_GREEK_FIRST, CP_GREEK_LAST);
                2: cp = $urandom_range(CP_CYRIL_FIRST, CP_CYRIL_LAST);
                3: cp = $urandom_range(CP_ARMEN_FIRST, CP_ARMEN_LAST);
                4: cp = range_edges[$urandom_range(0, range_edges.size() - 1)];
                default: cp = $urandom_range(0, 'h7FF);
            endcase
            plan_code(cp, 2);
        end else if (roll < 70) begin
            k = $urandom_range(0, 9);
            if (k == 0)
                cp = CP_BMP_LAST;
            else if (k < 3)
                cp = $urandom_range(0, 'h7FF);
            else
                cp = $urandom_range(0, CP_BMP_LAST);
            plan_code(cp, 3);
        end else if (roll < 76) begin
            k = $urandom_range(0, 9);
            if (k == 0)
                cp = 'h1FFFFF;
            else if (k == 1)
                cp = CP_BMP_LAST + 1;
            else if (k < 4)
                cp = $urandom_range(0, CP_BMP_LAST);
            else
                cp = $urandom_range(0, 'h1FFFFF);
            plan_code(cp, 4);
        end else if (roll < 82) begin
            if ($urandom_range(0, 1) != 0)
                text_plan.push_back(8'($urandom_range('h80, 'hBF)));
            else
                text_plan.push_back(8'($urandom_range('hF8, 'hFF)));
        end else if (roll < 88) begin
            // Broken sequence: cut short by a zero, or junk as continuations
            len = $urandom_range(2, 4);
            case (len)
                2: text_plan.push_back({LEAD_TWO, 5'($urandom)});
                3: text_plan.push_back({LEAD_THREE, 4'($urandom)});
                default: text_plan.push_back({LEAD_FOUR, 3'($urandom)});
            endcase
            if ($urandom_range(0, 1) != 0) begin
                k = $urandom_range(0, len - 2);
                repeat (k) text_plan.push_back({CONT_MARK, 6'($urandom)});
                text_plan.push_back(END_OF_TEXT);
            end else begin
                repeat (len - 1) text_plan.push_back(8'($urandom_range(1, 255)));
            end
        end else if (roll < 94) begin
            text_plan.push_back(8'($urandom_range(0, 255)));
        end else begin
            text_plan.push_back(END_OF_TEXT);
        end
    endfunction

    task automatic run_random(int unsigned items);
        int unsigned sent;
        sent = 0;
        while (sent < items) begin
            plan_unit();
            sent += text_plan.size();
            send_plan();
            // Now and then let the output side drain completely
            if ($urandom_range(0, 99) == 0)
                wait_idle();
            if ($urandom_range(0, 49) == 0)
                tx_steady = !tx_steady;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] nh, nw, lh, lw;
        int unsigned i;

        text_ch.valid   = 1'b0;
        text_ch.byte_in = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_FONT_SIZE;
        cfg_ch.data     = '0;
        rst_n           = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: directed text, then random text
        text_plan = opening_text;
        send_plan();
        wait_idle();
        run_random(300);

        // Smallest sizes: ASCII matches the 1x1 normal font, zero bytes per glyph
        wait_idle();
        load_config(16'h0101, 8'd1, 8'd1, 8'd1, 8'd1, '0, '0, '0);
        run_random(150);

        // Largest sizes and bases: 510-pixel unicode glyphs, addresses wrap
        wait_idle();
        load_config(16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255, '1, '1, '1);
        run_random(150);

        // Large ASCII font selected
        wait_idle();
        nh = 8'($urandom_range(1, 255));
        nw = 8'($urandom_range(1, 255));
        lh = 8'($urandom_range(1, 255));
        lw = (nw == 8'd255) ? 8'd254 : nw + 8'd1;
        load_config({lh, lw}, nh, nw, lh, lw, $urandom, $urandom, $urandom);
        run_random(150);

        // Font that only the default range fits: ASCII drawn from unicode bitmaps
        wait_idle();
        nh = 8'($urandom_range(1, 255));
        nw = 8'($urandom_range(1, 127));
        lh = nh;
        lw = {nw[6:0], 1'b1};
        load_config({nh, nw[6:0], 1'b0}, nh, nw, lh, lw, $urandom, $urandom, $urandom);
        run_random(150);

        // Fully random registers; ASCII mostly finds no glyph
        wait_idle();
        load_config(16'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                    8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                    $urandom, $urandom, $urandom);
        run_random(150);

        // One string with no gaps on either side
        wait_idle();
        nh = 8'($urandom_range(1, 255));
        nw = 8'($urandom_range(1, 255));
        load_config({nh, nw}, nh, nw, 8'($urandom_range(1, 255)),
                    8'($urandom_range(1, 255)), $urandom, $urandom, $urandom);
        rx_free = 1'b1;
        for (i = 0; i < STEADY_CHARS; i++)
            send_byte(8'($urandom_range(1, 127)), 0);
        send_byte(END_OF_TEXT, 0);
        rx_free = 1'b0;

        // Back to random text after the steady string, then drain
        run_random(50);
        wait_idle();
        tracker.final_check();

        $display("testbench: %0d bytes, %0d results, %0d string ends, %0d without glyph",
                 tracker.bytes_seen, tracker.results_checked, tracker.strings_ended,
                 tracker.no_glyph_seen);
        $display("testbench: %0d register settings, %0d failures",
                 configs_loaded, tracker.errors);
        if (tracker.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Hard limit on the whole run
    initial
    begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ugl_pkg.sv
rtl/core/ugl_byte_if.sv
rtl/core/ugl_result_if.sv
rtl/core/ugl_cfg_if.sv
rtl/core/ugl_ctrl.sv
rtl/core/ugl_dpath.sv
rtl/core/utf8_glyph_locator_core.sv
test/testbench.sv
